// ===== src/ppw_pkg.sv =====
// Package for the winding-number point-in-polygon block.
// Holds payload structs, opcode and status codes, and the cell/edge control and status types.
// No dependencies.
package ppw_pkg;

   localparam int COORD_BITS   = 16;
   localparam int MAX_VERTICES = 64;

   localparam logic [1:0] OP_CLEAR  = 2'd0;
   localparam logic [1:0] OP_APPEND = 2'd1;
   localparam logic [1:0] OP_TEST   = 2'd2;

   localparam logic [1:0] STATUS_OK       = 2'd0;
   localparam logic [1:0] STATUS_OPEN     = 2'd1;
   localparam logic [1:0] STATUS_OVERFLOW = 2'd2;

   typedef struct packed {
      logic [1:0]                   opcode;
      logic signed [COORD_BITS-1:0] coord_x;
      logic signed [COORD_BITS-1:0] coord_y;
   } req_type;

   typedef struct packed {
      logic       inside_flag;
      logic [1:0] status;
   } rsp_type;

   typedef struct packed {
      logic signed [COORD_BITS-1:0] x;
      logic signed [COORD_BITS-1:0] y;
   } vertex_type;

   typedef enum logic [1:0] {
      CELL_HOLD,
      CELL_PUSH,
      CELL_ROTATE
   } cell_mode_type;

   typedef struct packed {
      logic valid;
      logic clear;
   } edge_ctl_type;

   typedef struct packed {
      logic pending;
      logic wn_nonzero;
   } edge_stat_type;

endpackage

// ===== src/ppw_cell.sv =====
// One vertex cell of the vertex chain.
// Depends on ppw_pkg for vertex_type and cell_mode_type.
// Holds, takes a new vertex from the left, or takes the right neighbor's vertex.
module ppw_cell (
   input  logic                  clock,
   input  ppw_pkg::cell_mode_type mode,
   input  ppw_pkg::vertex_type    push_data,
   input  ppw_pkg::vertex_type    rot_data,
   output ppw_pkg::vertex_type    q
);

   ppw_pkg::vertex_type vtx_ff;
   ppw_pkg::vertex_type vtx_in;

   always_comb begin
      unique case (mode)
         ppw_pkg::CELL_PUSH:   vtx_in = push_data;
         ppw_pkg::CELL_ROTATE: vtx_in = rot_data;
         default:              vtx_in = vtx_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      vtx_ff <= vtx_in;
   end

   assign q = vtx_ff;

endmodule

// ===== src/ppw_edge.sv =====
// Edge unit: pipelined crossing test and winding-number accumulator.
// Depends on ppw_pkg for vertex_type, edge_ctl_type and edge_stat_type.
// Stages: differences, products, signed compare and accumulate.
module ppw_edge #(
   parameter int MAX_VERTICES = ppw_pkg::MAX_VERTICES
) (
   input  logic                  clock,
   input  logic                  reset,
   input  ppw_pkg::edge_ctl_type ctl,
   input  ppw_pkg::vertex_type   v0,
   input  ppw_pkg::vertex_type   v1,
   input  ppw_pkg::vertex_type   point,
   output ppw_pkg::edge_stat_type stat
);

   localparam int W    = ppw_pkg::COORD_BITS;
   localparam int WN_W = $clog2(MAX_VERTICES) + 2;

   // stage A
   logic                a_valid_ff, a_valid_in;
   logic                a_up_ff, a_up_in, a_down_ff, a_down_in;
   logic signed [W:0]   a_dx_ff, a_dx_in, a_dyp_ff, a_dyp_in;
   logic signed [W:0]   a_dxp_ff, a_dxp_in, a_dy_ff, a_dy_in;
   // stage B
   logic                b_valid_ff, b_valid_in;
   logic                b_up_ff, b_up_in, b_down_ff, b_down_in;
   logic signed [2*W+1:0] b_p_ff, b_p_in, b_q_ff, b_q_in;
   // accumulate
   logic signed [2*W+2:0] diff;
   logic signed [WN_W-1:0] wn_ff, wn_in;

   always_comb begin
      a_valid_in = ctl.valid;
      a_up_in    = ctl.valid && (point.y >= v0.y) && (point.y < v1.y);
      a_down_in  = ctl.valid && (point.y < v0.y) && (point.y >= v1.y);
      a_dx_in    = (W+1)'(v1.x) - (W+1)'(v0.x);
      a_dyp_in   = (W+1)'(point.y) - (W+1)'(v0.y);
      a_dxp_in   = (W+1)'(point.x) - (W+1)'(v0.x);
      a_dy_in    = (W+1)'(v1.y) - (W+1)'(v0.y);

      b_valid_in = a_valid_ff;
      b_up_in    = a_up_ff;
      b_down_in  = a_down_ff;
      b_p_in     = (2*W+2)'(a_dx_ff) * (2*W+2)'(a_dyp_ff);
      b_q_in     = (2*W+2)'(a_dxp_ff) * (2*W+2)'(a_dy_ff);

      diff = (2*W+3)'(b_p_ff) - (2*W+3)'(b_q_ff);

      wn_in = wn_ff;
      if (ctl.clear) begin
         wn_in = '0;
      end else if (b_up_ff && (diff > 0)) begin
         wn_in = wn_ff + WN_W'(1);
      end else if (b_down_ff && (diff < 0)) begin
         wn_in = wn_ff - WN_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         a_valid_ff <= 1'b0;
         a_up_ff    <= 1'b0;
         a_down_ff  <= 1'b0;
         b_valid_ff <= 1'b0;
         b_up_ff    <= 1'b0;
         b_down_ff  <= 1'b0;
         wn_ff      <= '0;
      end else begin
         a_valid_ff <= a_valid_in;
         a_up_ff    <= a_up_in;
         a_down_ff  <= a_down_in;
         b_valid_ff <= b_valid_in;
         b_up_ff    <= b_up_in;
         b_down_ff  <= b_down_in;
         wn_ff      <= wn_in;
      end
      a_dx_ff  <= a_dx_in;
      a_dyp_ff <= a_dyp_in;
      a_dxp_ff <= a_dxp_in;
      a_dy_ff  <= a_dy_in;
      b_p_ff   <= b_p_in;
      b_q_ff   <= b_q_in;
   end

   assign stat.pending    = a_valid_ff || b_valid_ff;
   assign stat.wn_nonzero = (wn_ff != '0);

endmodule

// ===== src/point_in_polygon_winding.sv =====
// Winding-number point-in-polygon test over a chain of vertex cells.
// Clear, append and unused opcodes leave busy low.
// A test that fails the overflow, closure or bounding-box check answers in the cycle after accept.
// A full test rotates the whole chain through the edge unit in ST_WALK, then waits in ST_DRAIN
// until the edge pipeline is empty, and then the answer strobes.
// Synchronous reset empties the table and clears invert_ff; the receiver cannot stall.
module point_in_polygon_winding #(
   parameter int MAX_VERTICES = ppw_pkg::MAX_VERTICES
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   output logic             busy,
   input  ppw_pkg::req_type req_data,
   output logic             rsp_valid,
   output ppw_pkg::rsp_type rsp_data,
   input  logic             csr_write_en,
   input  logic             csr_write_data
);

   localparam int CNT_W  = $clog2(MAX_VERTICES + 1);
   localparam int STEP_W = $clog2(MAX_VERTICES);

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_WALK,
      ST_DRAIN
   } state_type;

   // control state
   state_type            state_ff, state_in;
   logic [CNT_W-1:0]     count_ff, count_in;
   logic                 overflow_ff, overflow_in;
   logic                 invert_ff, invert_in;
   logic [STEP_W-1:0]    step_ff, step_in;
   logic                 rsp_valid_ff, rsp_valid_in;
   // payload state
   ppw_pkg::rsp_type     rsp_data_ff, rsp_data_in;
   ppw_pkg::vertex_type  first_ff, first_in;
   ppw_pkg::vertex_type  point_ff, point_in;
   logic signed [ppw_pkg::COORD_BITS-1:0] min_x_ff, min_x_in, max_x_ff, max_x_in;
   logic signed [ppw_pkg::COORD_BITS-1:0] min_y_ff, min_y_in, max_y_ff, max_y_in;

   // chain and edge unit
   ppw_pkg::cell_mode_type cell_mode;
   ppw_pkg::vertex_type    new_vtx;
   ppw_pkg::vertex_type    cell_q [MAX_VERTICES];
   ppw_pkg::edge_ctl_type  edge_ctl;
   ppw_pkg::edge_stat_type edge_stat;

   logic             accept;
   logic             full;
   logic             out_of_box;
   logic [CNT_W-1:0] step_next;

   assign accept    = start && (state_ff == ST_IDLE);
   assign full      = (count_ff == CNT_W'(MAX_VERTICES));
   assign new_vtx.x = req_data.coord_x;
   assign new_vtx.y = req_data.coord_y;
   assign step_next = CNT_W'(step_ff) + CNT_W'(1);

   assign out_of_box = (req_data.coord_x < min_x_ff) || (req_data.coord_x > max_x_ff) ||
                       (req_data.coord_y < min_y_ff) || (req_data.coord_y > max_y_ff);

   // Cell 0 holds the newest vertex; a push shifts everything one cell deeper.
   // During a walk the chain rotates toward cell 0, so cells 1 and 0 present
   // consecutive edges to the edge unit, and a full turn restores the order.
   for (genvar k = 0; k < MAX_VERTICES; k++) begin : g_cell
      ppw_pkg::vertex_type push_src;
      if (k == 0) begin : g_head
         assign push_src = new_vtx;
      end else begin : g_body
         assign push_src = cell_q[k-1];
      end
      ppw_cell u_cell (
         .clock     (clock),
         .mode      (cell_mode),
         .push_data (push_src),
         .rot_data  (cell_q[(k+1) % MAX_VERTICES]),
         .q         (cell_q[k])
      );
   end

   ppw_edge #(
      .MAX_VERTICES (MAX_VERTICES)
   ) u_edge (
      .clock (clock),
      .reset (reset),
      .ctl   (edge_ctl),
      .v0    (cell_q[1]),
      .v1    (cell_q[0]),
      .point (point_ff),
      .stat  (edge_stat)
   );

   always_comb begin
      state_in       = state_ff;
      count_in       = count_ff;
      overflow_in    = overflow_ff;
      invert_in      = csr_write_en ? csr_write_data : invert_ff;
      step_in        = step_ff;
      rsp_valid_in   = 1'b0;
      rsp_data_in    = rsp_data_ff;
      first_in       = first_ff;
      point_in       = point_ff;
      min_x_in       = min_x_ff;
      max_x_in       = max_x_ff;
      min_y_in       = min_y_ff;
      max_y_in       = max_y_ff;
      cell_mode      = ppw_pkg::CELL_HOLD;
      edge_ctl.valid = 1'b0;
      edge_ctl.clear = 1'b0;

      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               unique case (req_data.opcode)
                  ppw_pkg::OP_CLEAR: begin
                     count_in    = '0;
                     overflow_in = 1'b0;
                  end
                  ppw_pkg::OP_APPEND: begin
                     if (full) begin
                        // drop the vertex, remember the loss until the next clear
                        overflow_in = 1'b1;
                     end else begin
                        cell_mode = ppw_pkg::CELL_PUSH;
                        count_in  = count_ff + CNT_W'(1);
                        if (count_ff == '0) begin
                           first_in = new_vtx;
                           min_x_in = req_data.coord_x;
                           max_x_in = req_data.coord_x;
                           min_y_in = req_data.coord_y;
                           max_y_in = req_data.coord_y;
                        end else begin
                           if (req_data.coord_x < min_x_ff) min_x_in = req_data.coord_x;
                           if (req_data.coord_x > max_x_ff) max_x_in = req_data.coord_x;
                           if (req_data.coord_y < min_y_ff) min_y_in = req_data.coord_y;
                           if (req_data.coord_y > max_y_ff) max_y_in = req_data.coord_y;
                        end
                     end
                  end
                  ppw_pkg::OP_TEST: begin
                     // overflow outranks the closure check; both answer outside
                     priority if (overflow_ff) begin
                        rsp_valid_in          = 1'b1;
                        rsp_data_in.inside_flag = invert_ff;
                        rsp_data_in.status    = ppw_pkg::STATUS_OVERFLOW;
                     end else if ((count_ff == '0) || (first_ff != cell_q[0])) begin
                        rsp_valid_in          = 1'b1;
                        rsp_data_in.inside_flag = invert_ff;
                        rsp_data_in.status    = ppw_pkg::STATUS_OPEN;
                     end else if (out_of_box) begin
                        rsp_valid_in          = 1'b1;
                        rsp_data_in.inside_flag = invert_ff;
                        rsp_data_in.status    = ppw_pkg::STATUS_OK;
                     end else begin
                        point_in       = new_vtx;
                        step_in        = '0;
                        edge_ctl.clear = 1'b1;
                        state_in       = ST_WALK;
                     end
                  end
                  default: begin
                     // unused opcode: no result, no change
                  end
               endcase
            end
         end
         ST_WALK: begin
            // rotate one cell per cycle; only the first count-1 pairs are real edges
            cell_mode      = ppw_pkg::CELL_ROTATE;
            edge_ctl.valid = (step_next < count_ff);
            step_in        = step_ff + STEP_W'(1);
            if (step_ff == STEP_W'(MAX_VERTICES - 1)) begin
               state_in = ST_DRAIN;
            end
         end
         ST_DRAIN: begin
            // wait for the last edge to leave the pipeline, then answer
            if (!edge_stat.pending) begin
               rsp_valid_in            = 1'b1;
               rsp_data_in.inside_flag = edge_stat.wn_nonzero ^ invert_ff;
               rsp_data_in.status      = ppw_pkg::STATUS_OK;
               state_in                = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         count_ff     <= '0;
         overflow_ff  <= 1'b0;
         invert_ff    <= 1'b0;
         step_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         overflow_ff  <= overflow_in;
         invert_ff    <= invert_in;
         step_ff      <= step_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      rsp_data_ff <= rsp_data_in;
      first_ff    <= first_in;
      point_ff    <= point_in;
      min_x_ff    <= min_x_in;
      max_x_ff    <= max_x_in;
      min_y_ff    <= min_y_in;
      max_y_ff    <= max_y_in;
   end

   assign busy      = (state_ff != ST_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

// ===== tb/testbench.sv =====
// Self-checking testbench for point_in_polygon_winding: vertex table, box and winding walk.
// Drives clear/append/test transactions and checks answers against a scoreboard predictor.
// Depends on ppw_pkg (payload structs, opcode and status codes) and the block's RTL.
`timescale 1ns / 100ps

module testbench;

   // Opcode 3 has no name in the package; the block must ignore it.
   localparam logic [1:0] OP_UNUSED = 2'd3;

   // A full test walks the whole chain, so allow the table depth plus margin.
   localparam int     DRAIN_CYCLES = ppw_pkg::MAX_VERTICES + 8;
   localparam int     RANDOM_ITEMS = 1800;
   localparam int     PHASE_ITEMS  = 300;
   localparam longint LIMIT_NS     = 12_000_000;

   // Predicts each answer from its own copy of the table and box, and checks
   // answers in arrival order against the oldest prediction.
   class winding_scoreboard;
      bit               invert;
      longint           vx [ppw_pkg::MAX_VERTICES];
      longint           vy [ppw_pkg::MAX_VERTICES];
      int unsigned      count;
      bit               overflow;
      longint           box_min_x, box_max_x, box_min_y, box_max_y;
      ppw_pkg::rsp_type expected_answers [$];
      int unsigned      failures, checked;
      int unsigned      n_inside, n_outside, n_open, n_overflow;

      function void set_invert(bit value);
         invert = value;
      endfunction

      function int pending();
         return expected_answers.size();
      endfunction

      // Exact sign of the cross product of edge i against the point.
      function int edge_side(int unsigned i, longint px, longint py);
         longint d;
         d = (vx[i+1] - vx[i]) * (py - vy[i]) - (px - vx[i]) * (vy[i+1] - vy[i]);
         return (d > 0) ? 1 : ((d < 0) ? -1 : 0);
      endfunction

      function ppw_pkg::rsp_type classify_point(longint px, longint py);
         ppw_pkg::rsp_type a;
         int               wn;
         a.inside_flag = invert;
         a.status      = ppw_pkg::STATUS_OK;
         wn            = 0;
         if (overflow) begin
            a.status = ppw_pkg::STATUS_OVERFLOW;
            return a;
         end
         if (count == 0 || vx[0] != vx[count-1] || vy[0] != vy[count-1]) begin
            a.status = ppw_pkg::STATUS_OPEN;
            return a;
         end
         if (px < box_min_x || px > box_max_x || py < box_min_y || py > box_max_y)
            return a;
         for (int unsigned i = 0; i + 1 < count; i++) begin
            if (py >= vy[i]) begin
               if (py < vy[i+1] && edge_side(i, px, py) > 0) wn++;
            end else begin
               if (py >= vy[i+1] && edge_side(i, px, py) < 0) wn--;
            end
         end
         if (wn != 0) a.inside_flag = ~invert;
         return a;
      endfunction

      function void note_request(ppw_pkg::req_type r);
         longint           px, py;
         ppw_pkg::rsp_type a;
         px = longint'($signed(r.coord_x));
         py = longint'($signed(r.coord_y));
         case (r.opcode)
            ppw_pkg::OP_CLEAR: begin
               count    = 0;
               overflow = 0;
            end
            ppw_pkg::OP_APPEND: begin
               if (count >= ppw_pkg::MAX_VERTICES) begin
                  overflow = 1;
               end else begin
                  vx[count] = px;
                  vy[count] = py;
                  if (count == 0) begin
                     box_min_x = px; box_max_x = px;
                     box_min_y = py; box_max_y = py;
                  end else begin
                     if (px < box_min_x) box_min_x = px;
                     if (px > box_max_x) box_max_x = px;
                     if (py < box_min_y) box_min_y = py;
                     if (py > box_max_y) box_max_y = py;
                  end
                  count++;
               end
            end
            ppw_pkg::OP_TEST: begin
               a = classify_point(px, py);
               expected_answers.push_back(a);
               if (a.status == ppw_pkg::STATUS_OVERFLOW) n_overflow++;
               else if (a.status == ppw_pkg::STATUS_OPEN) n_open++;
               else if (a.inside_flag != invert) n_inside++;
               else n_outside++;
            end
            default: ;
         endcase
      endfunction

      function void check_result(ppw_pkg::rsp_type got);
         ppw_pkg::rsp_type want;
         if (expected_answers.size() == 0) begin
            $error("unexpected answer: inside_flag %0d status %0d",
                   got.inside_flag, got.status);
            failures++;
            return;
         end
         want = expected_answers.pop_front();
         checked++;
         if (got.inside_flag !== want.inside_flag) begin
            $error("inside_flag mismatch: expected %0d, actual %0d",
                   want.inside_flag, got.inside_flag);
            failures++;
         end
         if (got.status !== want.status) begin
            $error("status mismatch: expected %0d, actual %0d", want.status, got.status);
            failures++;
         end
      endfunction
   endclass

   logic             clock;
   logic             reset          = 1'b1;
   logic             start          = 1'b0;
   logic             busy;
   ppw_pkg::req_type req_data       = '0;
   logic             rsp_valid;
   ppw_pkg::rsp_type rsp_data;
   logic             csr_write_en   = 1'b0;
   logic             csr_write_data = 1'b0;

   winding_scoreboard sb;
   bit                idle_on = 1'b1;
   int unsigned       items_sent;
   int unsigned       phases;

   point_in_polygon_winding u_dut (
      .clock          (clock),
      .reset          (reset),
      .start          (start),
      .busy           (busy),
      .req_data       (req_data),
      .rsp_valid      (rsp_valid),
      .rsp_data       (rsp_data),
      .csr_write_en   (csr_write_en),
      .csr_write_data (csr_write_data)
   );

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   // Hard stop in case the block hangs or drops an answer.
   initial begin
      #(LIMIT_NS);
      $display("status: fail");
      $finish;
   end

   // Check every strobed answer at the edge that ends its cycle.
   always @(posedge clock) begin
      if (reset === 1'b0 && rsp_valid === 1'b1) sb.check_result(rsp_data);
   end

   // Pick a coordinate: a tight grid (lots of ties on edges and vertices),
   // a medium window, or the full signed range with its extremes.
   function automatic longint pick_coord(int scale);
      case (scale)
         0:       return longint'(int'($urandom_range(16)) - 8);
         1:       return longint'(int'($urandom_range(2000)) - 1000);
         default: begin
            case ($urandom_range(7))
               0:       return -32768;
               1:       return 32767;
               default: return longint'($signed(16'($urandom)));
            endcase
         end
      endcase
   endfunction

   // Drive one transaction starting at a falling edge; return at the falling
   // edge after acceptance with start still high, so back-to-back items flow.
   task automatic send_req(input logic [1:0] op, input longint x, input longint y);
      ppw_pkg::req_type r;
      if (idle_on && $urandom_range(99) < 6) begin
         start <= 1'b0;
         repeat ($urandom_range(1, 10)) @(negedge clock);
      end
      r.opcode  = op;
      r.coord_x = x[15:0];
      r.coord_y = y[15:0];
      start    <= 1'b1;
      req_data <= r;
      // Hold the transaction until an edge sees busy low.
      do @(posedge clock); while (busy !== 1'b0);
      sb.note_request(r);
      if (op != OP_UNUSED) items_sent++;
      @(negedge clock);
   endtask

   // Drop start, wait out every expected answer, then the block's latency.
   task automatic settle();
      start <= 1'b0;
      while (sb.pending() != 0) @(negedge clock);
      repeat (DRAIN_CYCLES) @(negedge clock);
   endtask

   task automatic write_invert(input bit value);
      settle();
      csr_write_en   <= 1'b1;
      csr_write_data <= value;
      sb.set_invert(value);
      @(negedge clock);
      csr_write_en   <= 1'b0;
      @(negedge clock);
   endtask

   // Append n vertices, optionally after a clear and closed back on the first.
   task automatic load_polygon(input int n, input int scale, input bit close_it,
                               input bit do_clear);
      longint fx, fy, x, y;
      fx = 0;
      fy = 0;
      if (do_clear) send_req(ppw_pkg::OP_CLEAR, pick_coord(2), pick_coord(2));
      for (int i = 0; i < n; i++) begin
         x = pick_coord(scale);
         y = pick_coord(scale);
         if (i == 0) begin
            fx = x;
            fy = y;
         end
         send_req(ppw_pkg::OP_APPEND, x, y);
      end
      if (close_it) send_req(ppw_pkg::OP_APPEND, fx, fy);
   endtask

   // Query points aimed at the box, at stored vertices and their neighbors,
   // or anywhere at all.
   task automatic query_points(input int k, input int scale);
      longint      px, py;
      int unsigned j;
      repeat (k) begin
         px = pick_coord(scale);
         py = pick_coord(scale);
         if (sb.count > 0) begin
            j = $urandom_range(sb.count - 1);
            case ($urandom_range(5))
               0, 1: begin
                  px = sb.box_min_x + longint'($urandom_range(int'(sb.box_max_x - sb.box_min_x)));
                  py = sb.box_min_y + longint'($urandom_range(int'(sb.box_max_y - sb.box_min_y)));
               end
               2: begin
                  px = sb.vx[j];
                  py = sb.vy[j];
               end
               3: begin
                  px = sb.vx[j] + longint'(int'($urandom_range(2)) - 1);
                  py = sb.vy[j] + longint'(int'($urandom_range(2)) - 1);
               end
               4: begin
                  px = $urandom_range(1) ? sb.box_min_x : sb.box_max_x;
                  py = sb.vy[j];
               end
               default: ;
            endcase
            // Stay inside the 16-bit field.
            if (px > 32767) px = 32767;
            if (px < -32768) px = -32768;
            if (py > 32767) py = 32767;
            if (py < -32768) py = -32768;
         end
         send_req(ppw_pkg::OP_TEST, px, py);
      end
   endtask

   initial begin
      int sel, n, scale;
      sb = new();

      // Hold reset, then release at a falling edge.
      repeat (10) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // ---- Directed part ----
      // Empty table counts as not closed.
      send_req(ppw_pkg::OP_TEST, 0, 0);
      // Single vertex: closed, no edges, always outside.
      send_req(ppw_pkg::OP_APPEND, 5, 5);
      send_req(ppw_pkg::OP_TEST, 5, 5);
      send_req(ppw_pkg::OP_TEST, 6, 5);
      send_req(ppw_pkg::OP_CLEAR, 0, 0);
      // Unused opcode must leave the table alone.
      send_req(OP_UNUSED, -1, -1);
      // Full-range square, first left open, then closed.
      send_req(ppw_pkg::OP_APPEND, -32768, -32768);
      send_req(ppw_pkg::OP_APPEND,  32767, -32768);
      send_req(ppw_pkg::OP_APPEND,  32767,  32767);
      send_req(ppw_pkg::OP_APPEND, -32768,  32767);
      send_req(ppw_pkg::OP_TEST, 0, 0);
      send_req(ppw_pkg::OP_APPEND, -32768, -32768);
      send_req(ppw_pkg::OP_TEST, 0, 0);
      send_req(ppw_pkg::OP_TEST, -32768, -32768);
      send_req(ppw_pkg::OP_TEST, 32767, 32767);
      send_req(ppw_pkg::OP_TEST, 32767, 0);
      send_req(ppw_pkg::OP_TEST, -32768, 0);
      send_req(ppw_pkg::OP_TEST, 0, -32768);
      send_req(ppw_pkg::OP_TEST, 0, 32767);
      send_req(ppw_pkg::OP_TEST, -1, -1);
      // Clockwise triangle: winding of minus one still means inside.
      send_req(ppw_pkg::OP_CLEAR, 0, 0);
      send_req(ppw_pkg::OP_APPEND, 0, 0);
      send_req(ppw_pkg::OP_APPEND, 0, 10);
      send_req(ppw_pkg::OP_APPEND, 10, 0);
      send_req(ppw_pkg::OP_APPEND, 0, 0);
      send_req(ppw_pkg::OP_TEST, 2, 2);
      send_req(ppw_pkg::OP_TEST, 20, 20);
      send_req(ppw_pkg::OP_TEST, 9, 9);

      // ---- Random part, split into phases with a register write between ----
      items_sent = 0;
      phases     = 0;
      while (items_sent < RANDOM_ITEMS) begin
         if (items_sent >= phases * PHASE_ITEMS) begin
            // Hit both extremes first, then let the seed choose.
            case (phases)
               0:       write_invert(1'b1);
               1:       write_invert(1'b0);
               default: write_invert($urandom_range(1));
            endcase
            // Keep one phase free of sender gaps.
            idle_on = (phases != 2);
            phases++;
         end
         sel   = $urandom_range(99);
         scale = $urandom_range(2);
         if (sel < 70) begin
            // Well-formed closed polygon, then a batch of queries.
            case ($urandom_range(24))
               0:       n = 63;
               1, 2:    n = $urandom_range(20, 62);
               3:       n = $urandom_range(1, 2);
               default: n = $urandom_range(3, 8);
            endcase
            load_polygon(n, scale, 1'b1, 1'b1);
            query_points($urandom_range(2, 8), scale);
         end else if (sel < 78) begin
            // Open polygon, sometimes appended onto whatever is stored.
            load_polygon($urandom_range(1, 6), scale, 1'b0, $urandom_range(3) != 0);
            query_points($urandom_range(1, 3), scale);
         end else if (sel < 84) begin
            // Fill or overrun the table, query, and sometimes clear and query empty.
            load_polygon($urandom_range(64, 70), scale, $urandom_range(1), 1'b1);
            query_points($urandom_range(1, 2), scale);
            if ($urandom_range(1)) begin
               send_req(ppw_pkg::OP_CLEAR, pick_coord(2), pick_coord(2));
               query_points(1, scale);
            end
         end else begin
            // Noise: any opcode with any coordinates.
            repeat ($urandom_range(1, 6))
               send_req(2'($urandom_range(3)), pick_coord(2), pick_coord(2));
         end
         // Now and then let the pipeline run dry before the next item.
         if ($urandom_range(19) == 0) settle();
      end

      // Drain everything and give stray answers time to show up.
      settle();

      $display("%0d random transactions over %0d register phases; %0d answers checked",
               items_sent, phases, sb.checked);
      $display("answers: %0d inside, %0d outside, %0d not closed, %0d overflowed",
               sb.n_inside, sb.n_outside, sb.n_open, sb.n_overflow);
      if (sb.failures == 0)
         $display("status: pass");
      else
         $display("status: fail");
      $finish;
   end

endmodule

// ===== sim.f =====
src/ppw_pkg.sv
src/ppw_cell.sv
src/ppw_edge.sv
src/point_in_polygon_winding.sv
tb/testbench.sv
